// ===== hw/rtl/plr_pkg.sv =====
// Shared types and constants for the planar line rasterizer.
// No dependencies; the modules reference this package by scoped name.
package plr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // request action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_STEP   = 2'd2
    } t_kind;

    // classified command passed from front end to back end
    typedef struct packed {
        t_kind              kind;
        logic               steep;
        logic [15:0]        maj_pos;
        logic [15:0]        maj_end;
        logic [15:0]        min_pos;
        logic [16:0]        span;
        logic signed [16:0] delta;
        logic [7:0]         color;
    } t_cmd;

endpackage

// ===== hw/rtl/plr_in_if.sv =====
// Request channel of the line rasterizer: valid/ready plus line payload.
// No dependencies.
interface plr_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  color;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;

    modport source (output valid, action, color, start_x, start_y, end_x, end_y,
                    input ready);
    modport sink   (input valid, action, color, start_x, start_y, end_x, end_y,
                    output ready);
endinterface

// ===== hw/rtl/plr_out_if.sv =====
// Pixel channel of the line rasterizer: valid/ready plus pixel payload.
// No dependencies.
interface plr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  plane;
    logic [13:0] plane_offset;
    logic [7:0]  pixel_color;
    logic        clipped;
    logic        last;
    logic        error;

    modport source (output valid, plane, plane_offset, pixel_color, clipped, last, error,
                    input ready);
    modport sink   (input valid, plane, plane_offset, pixel_color, clipped, last, error,
                    output ready);
endinterface

// ===== hw/rtl/plr_front.sv =====
// Front end: captures requests, takes endpoint differences, then classifies
// each request into a load, reject or step command. Depends on plr_pkg, plr_in_if.
module plr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    plr_in_if.sink        i_cmd,
    input  logic          i_full,
    output logic          o_push,
    output plr_pkg::t_cmd o_cmd
);

    logic               r_v1;
    logic               r_act;
    logic [7:0]         r_color;
    logic [15:0]        r_sx, r_sy, r_ex, r_ey;
    logic signed [16:0] r_dx, r_dy;

    logic               take;
    logic [16:0]        adx, ady;
    logic               steep, swap;

    assign o_push      = r_v1 && !i_full;
    assign i_cmd.ready = !r_v1 || o_push;
    assign take        = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_cmd.ready) begin
            r_v1 <= i_cmd.valid;
        end
        if (take) begin
            r_act   <= i_cmd.action;
            r_color <= i_cmd.color;
            r_sx    <= i_cmd.start_x;
            r_sy    <= i_cmd.start_y;
            r_ex    <= i_cmd.end_x;
            r_ey    <= i_cmd.end_y;
            r_dx    <= signed'({1'b0, i_cmd.end_x}) - signed'({1'b0, i_cmd.start_x});
            r_dy    <= signed'({1'b0, i_cmd.end_y}) - signed'({1'b0, i_cmd.start_y});
        end
    end

    always_comb begin
        adx   = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
        ady   = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);
        steep = ady > adx;
        swap  = steep ? r_dy[16] : r_dx[16];

        o_cmd         = '0;
        o_cmd.color   = r_color;
        o_cmd.steep   = steep;
        if (r_act == plr_pkg::ACT_STEP) begin
            o_cmd.kind = plr_pkg::KIND_STEP;
        end else if (r_dx == '0) begin
            o_cmd.kind = plr_pkg::KIND_REJECT;
        end else begin
            o_cmd.kind = plr_pkg::KIND_LOAD;
        end

        // walk the major axis upward from the smaller endpoint
        if (!steep) begin
            o_cmd.maj_pos = swap ? r_ex : r_sx;
            o_cmd.maj_end = swap ? r_sx : r_ex;
            o_cmd.min_pos = swap ? r_ey : r_sy;
            o_cmd.span    = adx;
            o_cmd.delta   = swap ? -r_dy : r_dy;
        end else begin
            o_cmd.maj_pos = swap ? r_ey : r_sy;
            o_cmd.maj_end = swap ? r_sy : r_ey;
            o_cmd.min_pos = swap ? r_ex : r_sx;
            o_cmd.span    = ady;
            o_cmd.delta   = swap ? -r_dx : r_dx;
        end
    end

endmodule

// ===== hw/rtl/plr_queue.sv =====
// Short command queue between front and back end, register based.
// Depends on plr_pkg.
module plr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  plr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output plr_pkg::t_cmd o_cmd
);

    plr_pkg::t_cmd                 r_mem [plr_pkg::QUEUE_DEPTH];
    logic [plr_pkg::QPTR_W-1:0]   r_wptr, r_rptr;
    logic [plr_pkg::QPTR_W:0]     r_count;

    logic do_pop;

    assign o_full  = r_count == (plr_pkg::QPTR_W+1)'(plr_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (plr_pkg::QPTR_W+1)'(plr_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/plr_back.sv =====
// Back end: holds the active line, steps the error term one pixel per cycle
// unless stalled, maps it to plane/byte. Depends on plr_pkg, plr_out_if.
module plr_back #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  plr_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    plr_out_if.source     o_pix
);

    localparam int XW     = $clog2(SCREEN_WIDTH);
    localparam int YW     = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int PIX_W  = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT) + 1;
    localparam int OFF_W  = (PIX_W < 16) ? 16 : PIX_W;

    // line state
    logic               r_active;
    logic               r_steep;
    logic [15:0]        r_maj_pos, r_maj_end, r_min_pos;
    logic [16:0]        r_span;
    logic signed [16:0] r_delta;
    logic signed [17:0] r_err;
    logic [7:0]         r_color;

    // execute stage result
    logic        r_e_valid;
    logic [15:0] r_e_px, r_e_py;
    logic        r_e_clip, r_e_last, r_e_err;
    logic [7:0]  r_e_color;

    // output register
    logic        r_o_valid;
    logic [1:0]  r_o_plane;
    logic [13:0] r_o_offset;
    logic [7:0]  r_o_color;
    logic        r_o_clip, r_o_last, r_o_err;

    logic               en;
    logic               n_e_valid;
    logic [15:0]        px, py;
    logic               is_last, clip;
    logic signed [17:0] err_sum, span_s;
    logic [OFF_W-1:0]   offset;

    assign en      = !r_o_valid || o_pix.ready;
    assign o_q_pop = en && i_q_valid;

    always_comb begin
        px      = r_steep ? r_min_pos : r_maj_pos;
        py      = r_steep ? r_maj_pos : r_min_pos;
        is_last = r_maj_pos == r_maj_end;
        clip    = (px >= 16'(SCREEN_WIDTH)) || (py >= 16'(SCREEN_HEIGHT));
        err_sum = r_err + {r_delta[16], r_delta};
        span_s  = signed'({1'b0, r_span});
        offset  = OFF_W'(r_e_py[YW-1:0]) * OFF_W'(SCREEN_WIDTH) + OFF_W'(r_e_px[XW-1:0]);
        // a reject always reports, a step only while a line is active
        n_e_valid = o_q_pop && ((i_q_cmd.kind == plr_pkg::KIND_REJECT) ||
                                (i_q_cmd.kind == plr_pkg::KIND_STEP && r_active));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_steep   <= 1'b0;
            r_maj_pos <= '0;
            r_maj_end <= '0;
            r_min_pos <= '0;
            r_span    <= '0;
            r_delta   <= '0;
            r_err     <= '0;
            r_color   <= '0;
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= n_e_valid;
            r_o_valid <= r_e_valid;
            if (o_q_pop) begin
                unique case (i_q_cmd.kind)
                    plr_pkg::KIND_LOAD: begin
                        r_active  <= 1'b1;
                        r_steep   <= i_q_cmd.steep;
                        r_maj_pos <= i_q_cmd.maj_pos;
                        r_maj_end <= i_q_cmd.maj_end;
                        r_min_pos <= i_q_cmd.min_pos;
                        r_span    <= i_q_cmd.span;
                        r_delta   <= i_q_cmd.delta;
                        r_err     <= '0;
                        r_color   <= i_q_cmd.color;
                    end
                    plr_pkg::KIND_REJECT: begin
                        r_active  <= 1'b0;
                    end
                    plr_pkg::KIND_STEP: begin
                        if (r_active) begin
                            if (is_last) begin
                                r_active <= 1'b0;
                            end else begin
                                r_maj_pos <= r_maj_pos + 1'b1;
                                if (err_sum >= span_s) begin
                                    r_err     <= err_sum - span_s;
                                    r_min_pos <= r_min_pos + 1'b1;
                                end else if (err_sum < 0) begin
                                    r_err     <= err_sum + span_s;
                                    r_min_pos <= r_min_pos - 1'b1;
                                end else begin
                                    r_err     <= err_sum;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload of the execute and output stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_q_pop) begin
                r_e_err   <= i_q_cmd.kind == plr_pkg::KIND_REJECT;
                r_e_px    <= px;
                r_e_py    <= py;
                r_e_clip  <= clip;
                r_e_last  <= is_last;
                r_e_color <= r_color;
            end
            // rejected lines report only the error flag
            if (r_e_err || r_e_clip) begin
                r_o_plane  <= '0;
                r_o_offset <= '0;
            end else begin
                r_o_plane  <= offset[1:0];
                r_o_offset <= offset[15:2];
            end
            r_o_color <= r_e_err ? 8'd0 : r_e_color;
            r_o_clip  <= !r_e_err && r_e_clip;
            r_o_last  <= !r_e_err && r_e_last;
            r_o_err   <= r_e_err;
        end
    end

    assign o_pix.valid        = r_o_valid;
    assign o_pix.plane        = r_o_plane;
    assign o_pix.plane_offset = r_o_offset;
    assign o_pix.pixel_color  = r_o_color;
    assign o_pix.clipped      = r_o_clip;
    assign o_pix.last         = r_o_last;
    assign o_pix.error        = r_o_err;

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_span != '0)
        else $error("active line with zero span");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_err >= 0) && (r_err < signed'({1'b0, r_span})))
        else $error("error term out of range");

    a_err_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err |-> !r_o_clip && !r_o_last && r_o_color == '0)
        else $error("error result carries pixel fields");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_clip |-> r_o_plane == '0 && r_o_offset == '0)
        else $error("clipped pixel has nonzero address");

endmodule

// ===== hw/rtl/planar_line_rasterizer.sv =====
// Line engine for a four-plane 256-color frame buffer. A start request loads
// two endpoints and a color (or returns an error result if both x are equal);
// each step request then returns one pixel as plane and byte within plane, with
// off-screen pixels flagged clipped. Requests and pixels both move at one per
// cycle sustained while the pixel output is ready. A step's pixel passes
// through capture, classification into the queue, the error-term step and
// the address multiply. The error-term update in the back end sets the rate.
// Depends on plr_pkg, plr_in_if, plr_out_if, plr_front, plr_queue, plr_back.
module planar_line_rasterizer #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plr_in_if.sink    i_cmd,
    plr_out_if.source o_pix
);

    logic          push, full, q_valid, q_pop;
    plr_pkg::t_cmd f_cmd, q_cmd;

    plr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (f_cmd)
    );

    plr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    plr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule
